@@ rtl/mi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mi_pkg;

    // width of the value, modulus and inverse ports
    localparam int IO_W = 32;

    // default operand width inside the block
    localparam int WIDTH_DEF = 32;

    // divider operand select
    localparam logic DIV_REDUCE = 1'b0;   // value / modulus
    localparam logic DIV_STEP   = 1'b1;   // r_prev / r_cur

    // result write codes
    localparam logic [1:0] RES_OK_ZERO = 2'd0;   // inverse 0, status ok
    localparam logic [1:0] RES_FAIL    = 2'd1;   // no inverse
    localparam logic [1:0] RES_INV     = 2'd2;   // signed-corrected coefficient

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load;        // latch operands, seed the recurrences
        logic       div_start;   // launch the shared divider
        logic       div_sel;     // DIV_REDUCE or DIV_STEP
        logic       reduce_wr;   // r_cur <= value mod modulus
        logic       step_wr;     // advance one euclid step
        logic       fix_wr;      // reduce coefficient magnitude below modulus
        logic       res_wr;      // write the result registers
        logic [1:0] res_op;      // which result to write
    } mi_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic mod_zero;
        logic mod_one;
        logic rcur_zero;
        logic rprev_one;
    } mi_stat_t;

endpackage

`default_nettype wire

@@ rtl/mi_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mi_divider #(
    parameter int WIDTH = mi_pkg::WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] dividend,
    input  wire logic [WIDTH-1:0] divisor,
    input  wire logic [WIDTH-1:0] mult,
    output logic                  done,
    output logic [WIDTH-1:0]      rem,
    output logic [WIDTH-1:0]      prod
);
    import mi_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(WIDTH - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] num_reg, num_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [WIDTH-1:0] mul_reg, mul_next;
    logic [WIDTH-1:0] prod_reg, prod_next;

    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             qbit;

    // one restoring step: trial subtract of the divisor
    assign shifted = {rem_reg, num_reg[WIDTH-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign qbit    = (shifted >= {1'b0, den_reg});

    // iteration control and operand registers
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        mul_next  = mul_reg;
        prod_next = prod_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            mul_next  = mult;
            prod_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            num_next  = {num_reg[WIDTH-2:0], 1'b0};
            // quotient bits arrive msb first, so q*mult builds up by horner
            prod_next = {prod_reg[WIDTH-2:0], 1'b0} + (qbit ? mul_reg : '0);
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        mul_reg  <= mul_next;
        prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ rtl/mi_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mi_datapath #(
    parameter int WIDTH = mi_pkg::WIDTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [WIDTH-1:0] value_in,
    input  wire logic [WIDTH-1:0] modulus_in,
    input  wire mi_pkg::mi_cmd_t  cmd,
    output mi_pkg::mi_stat_t      stat,
    output logic [WIDTH-1:0]      inverse_out,
    output logic                  status_out,
    output logic                  done_out
);
    import mi_pkg::*;

    logic [WIDTH-1:0] val_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] rprev_reg;
    logic [WIDTH-1:0] rcur_reg;
    logic [WIDTH-1:0] uprev_reg;
    logic [WIDTH-1:0] ucur_reg;
    logic             odd_reg;
    logic [WIDTH-1:0] inverse_reg;
    logic             status_reg;
    logic             done_reg;

    logic [WIDTH-1:0] div_num;
    logic [WIDTH-1:0] div_den;
    logic             div_done;
    logic [WIDTH-1:0] div_rem;
    logic [WIDTH-1:0] div_prod;

    // operand select for the shared divider
    assign div_num = (cmd.div_sel == DIV_STEP) ? rprev_reg : val_reg;
    assign div_den = (cmd.div_sel == DIV_STEP) ? rcur_reg  : mod_reg;

    mi_divider #(
        .WIDTH (WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .mult     (ucur_reg),
        .done     (div_done),
        .rem      (div_rem),
        .prod     (div_prod)
    );

    // euclid recurrences; coefficient magnitudes stay within the modulus
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            val_reg   <= value_in;
            mod_reg   <= modulus_in;
            rprev_reg <= modulus_in;
            uprev_reg <= '0;
            ucur_reg  <= WIDTH'(1);
            odd_reg   <= 1'b0;
        end
        if (cmd.reduce_wr)
        begin
            rcur_reg <= div_rem;
        end
        if (cmd.step_wr)
        begin
            rprev_reg <= rcur_reg;
            rcur_reg  <= div_rem;
            uprev_reg <= ucur_reg;
            ucur_reg  <= uprev_reg + div_prod;
            odd_reg   <= ~odd_reg;
        end
        if (cmd.fix_wr)
        begin
            if (uprev_reg >= mod_reg)
            begin
                uprev_reg <= uprev_reg - mod_reg;
            end
        end
    end

    // result registers; sign of the coefficient follows the step parity
    always_ff @(posedge clk)
    begin
        if (cmd.res_wr)
        begin
            case (cmd.res_op)
                RES_OK_ZERO:
                begin
                    inverse_reg <= '0;
                    status_reg  <= 1'b0;
                end
                RES_INV:
                begin
                    status_reg <= 1'b0;
                    if (odd_reg || (uprev_reg == '0))
                    begin
                        inverse_reg <= uprev_reg;
                    end
                    else
                    begin
                        inverse_reg <= mod_reg - uprev_reg;
                    end
                end
                default:
                begin
                    inverse_reg <= '0;
                    status_reg  <= 1'b1;
                end
            endcase
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.res_wr;
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.div_done  = div_done;
        stat.mod_zero  = (mod_reg == '0);
        stat.mod_one   = (mod_reg == WIDTH'(1));
        stat.rcur_zero = (rcur_reg == '0);
        stat.rprev_one = (rprev_reg == WIDTH'(1));
    end

    assign inverse_out = inverse_reg;
    assign status_out  = status_reg;
    assign done_out    = done_reg;

endmodule

`default_nettype wire

@@ rtl/mi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mi_pkg::mi_stat_t  stat,
    output mi_pkg::mi_cmd_t        cmd,
    output logic                   busy
);
    import mi_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHK_MOD = 3'd1;
    localparam logic [2:0] S_REDUCE  = 3'd2;
    localparam logic [2:0] S_CHK_REM = 3'd3;
    localparam logic [2:0] S_STEP    = 3'd4;
    localparam logic [2:0] S_FINAL   = 3'd5;

    logic [2:0] state_reg, state_next;

    // sequencing of the euclid loop
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK_MOD;
                end
            end
            S_CHK_MOD:
            begin
                if (stat.mod_zero)
                begin
                    cmd.res_wr = 1'b1;
                    cmd.res_op = RES_FAIL;
                    state_next = S_IDLE;
                end
                else if (stat.mod_one)
                begin
                    cmd.res_wr = 1'b1;
                    cmd.res_op = RES_OK_ZERO;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_REDUCE;
                    state_next    = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (stat.div_done)
                begin
                    cmd.reduce_wr = 1'b1;
                    state_next    = S_CHK_REM;
                end
            end
            S_CHK_REM:
            begin
                if (stat.rcur_zero)
                begin
                    if (stat.rprev_one)
                    begin
                        cmd.fix_wr = 1'b1;
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        cmd.res_wr = 1'b1;
                        cmd.res_op = RES_FAIL;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_STEP;
                    state_next    = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.div_sel = DIV_STEP;
                if (stat.div_done)
                begin
                    cmd.step_wr = 1'b1;
                    state_next  = S_CHK_REM;
                end
            end
            S_FINAL:
            begin
                cmd.res_wr = 1'b1;
                cmd.res_op = RES_INV;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

@@ rtl/modular_inverse.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                  transfer
// -------   ----------------------   -------------------------------------
// input     start, value, modulus    edge with start high and busy low
// result    done, inverse, status    the one cycle in which done is high
//
// an item runs one euclid step at a time on one shared bit-serial divider,
// one quotient bit per cycle, after an initial reduction of the value by
// the modulus; a zero or unit modulus is answered without the divider.
// reset clears the controller, the divider control and the done strobe;
// the receiver cannot stall, done lasts one cycle.

module modular_inverse #(
    parameter int WIDTH = mi_pkg::WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [mi_pkg::IO_W-1:0]   value,
    input  wire logic [mi_pkg::IO_W-1:0]   modulus,
    output logic                           done,
    output logic [mi_pkg::IO_W-1:0]        inverse,
    output logic                           status
);
    import mi_pkg::*;

    mi_cmd_t  cmd;
    mi_stat_t stat;

    logic [WIDTH+IO_W-1:0] value_ext;
    logic [WIDTH+IO_W-1:0] modulus_ext;
    logic [WIDTH+IO_W-1:0] inverse_ext;
    logic [WIDTH-1:0]      inverse_w;

    // inputs taken in their low WIDTH bits, zero extended if WIDTH is wider
    assign value_ext   = {{WIDTH{1'b0}}, value};
    assign modulus_ext = {{WIDTH{1'b0}}, modulus};

    mi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mi_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_in    (value_ext[WIDTH-1:0]),
        .modulus_in  (modulus_ext[WIDTH-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .inverse_out (inverse_w),
        .status_out  (status),
        .done_out    (done)
    );

    // fit the result to the port width
    assign inverse_ext = {{IO_W{1'b0}}, inverse_w};
    assign inverse     = inverse_ext[IO_W-1:0];

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import mi_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 20000;
    // quiet cycles after the last result, covers the slowest item
    localparam int TAIL_CYCLES    = 2000;

    typedef struct packed {
        logic [IO_W-1:0] inverse;
        logic            status;
    } inv_result_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic [IO_W-1:0] value;
    logic [IO_W-1:0] modulus;
    logic            done;
    logic [IO_W-1:0] inverse;
    logic            status;

    inv_result_t     pending_inverses[$];
    int              mismatches;
    int              items_sent;
    int              results_checked;
    int              no_inverse_seen;
    int              idle_cycles;
    int              burst_left;
    bit              start_on;

    modular_inverse DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .value   (value),
        .modulus (modulus),
        .done    (done),
        .inverse (inverse),
        .status  (status)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // extended euclid on magnitudes, sign recovered from the step count parity
    function automatic inv_result_t predict_inverse(input logic [IO_W-1:0] a,
                                                    input logic [IO_W-1:0] m);
        inv_result_t res;
        logic [63:0] r_prev;
        logic [63:0] r_cur;
        logic [63:0] u_prev;
        logic [63:0] u_cur;
        logic [63:0] quot;
        logic [63:0] r_next;
        logic [63:0] u_next;
        logic [63:0] mag;
        int unsigned steps;
        res.inverse = '0;
        res.status  = 1'b0;
        if (m == 1)
        begin
            return res;
        end
        if (m == 0)
        begin
            res.status = 1'b1;
            return res;
        end
        r_prev = 64'(m);
        r_cur  = 64'(a) % 64'(m);
        u_prev = 64'd0;
        u_cur  = 64'd1;
        steps  = 0;
        while (r_cur != 0)
        begin
            quot   = r_prev / r_cur;
            r_next = r_prev - quot * r_cur;
            u_next = u_prev + quot * u_cur;
            r_prev = r_cur;
            r_cur  = r_next;
            u_prev = u_cur;
            u_cur  = u_next;
            steps++;
        end
        if (r_prev != 1)
        begin
            res.status = 1'b1;
            return res;
        end
        mag = u_prev % 64'(m);
        if (steps[0])
            res.inverse = mag[IO_W-1:0];
        else if (mag == 0)
            res.inverse = '0;
        else
            res.inverse = IO_W'(64'(m) - mag);
        return res;
    endfunction

    // random value of random bit length, for narrow operands
    function automatic logic [IO_W-1:0] rand_narrow();
        return $urandom >> $urandom_range(0, IO_W - 1);
    endfunction

    // append one expected result at the tail of the queue
    function automatic void enqueue_expected(input inv_result_t r);
        pending_inverses.insert(pending_inverses.size(), r);
    endfunction

    // result checker: done is a one-cycle strobe, no back pressure
    always @(posedge clk)
    begin : result_check
        inv_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_inverses.size() == 0)
            begin
                $display("%0t: unexpected result inverse %h status %b",
                         $time, inverse, status);
                mismatches++;
            end
            else
            begin
                exp_res = pending_inverses.pop_front();
                results_checked++;
                if (status)
                    no_inverse_seen++;
                if (inverse !== exp_res.inverse)
                begin
                    $display("%0t: inverse mismatch expected %h actual %h",
                             $time, exp_res.inverse, inverse);
                    mismatches++;
                end
                if (status !== exp_res.status)
                begin
                    $display("%0t: status mismatch expected %b actual %b",
                             $time, exp_res.status, status);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, pending_inverses.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // one input transfer; bursts of random length with random gaps between
    task automatic send_item(input logic [IO_W-1:0] v, input logic [IO_W-1:0] m);
        int gap;
        start   <= 1'b1;
        value   <= v;
        modulus <= m;
        start_on = 1'b1;
        do
            @(posedge clk);
        while (busy);
        enqueue_expected(predict_inverse(v, m));
        items_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            start   <= 1'b0;
            start_on = 1'b0;
            case ($urandom_range(0, 9))
                0:       gap = $urandom_range(100, 2500);
                1, 2:    gap = $urandom_range(20, 200);
                default: gap = $urandom_range(1, 8);
            endcase
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // lower start and wait until every expected result has arrived
    task automatic drain();
        if (start_on)
        begin
            start   <= 1'b0;
            start_on = 1'b0;
            @(posedge clk);
        end
        while (pending_inverses.size() != 0)
            @(posedge clk);
    endtask

    // modulus one gives 0 ok, modulus zero gives no inverse
    task automatic test_special_moduli();
        send_item(32'd0, 32'd1);
        send_item(32'hFFFF_FFFF, 32'd1);
        send_item(32'd12345, 32'd1);
        send_item(32'd5, 32'd0);
        send_item(32'd0, 32'd0);
        send_item(32'hFFFF_FFFF, 32'd0);
        drain();
    endtask

    // zero value, multiples, shared factors, value above modulus
    task automatic test_degenerate_values();
        send_item(32'd0, 32'd7);
        send_item(32'd0, 32'd2);
        send_item(32'd21, 32'd7);
        send_item(32'd6, 32'd9);
        send_item(32'd3, 32'hFFFF_FFFF);
        send_item(32'd100, 32'd7);
        send_item(32'hFFFF_FFFF, 32'd2);
        drain();
    endtask

    // operand extremes and the longest euclid chain
    task automatic test_operand_extremes();
        send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_item(32'd2, 32'hFFFF_FFFF);
        send_item(32'd1, 32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_item(32'd1836311903, 32'd2971215073);
        send_item(32'd2971215073, 32'd1836311903);
        send_item(32'd1, 32'd2);
        send_item(32'd3, 32'd2);
        send_item($urandom, 32'd4294967291);
        send_item(32'd4294967290, 32'd4294967291);
        drain();
    endtask

    // well-formed items: operands retried, up to four tries, until an inverse exists
    task automatic test_random_coprime(input int count);
        logic [IO_W-1:0] v;
        logic [IO_W-1:0] m;
        inv_result_t     probe;
        int tries;
        repeat (count)
        begin
            tries = 0;
            do
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    m = rand_narrow();
                    v = rand_narrow();
                end
                else
                begin
                    m = $urandom;
                    v = $urandom;
                end
                probe = predict_inverse(v, m);
                tries++;
            end
            while (probe.status && tries < 4);
            send_item(v, m);
        end
    endtask

    // value and modulus built from a common factor
    task automatic test_random_shared_factor(input int count);
        logic [IO_W-1:0] g;
        repeat (count)
        begin
            g = $urandom_range(2, 65535);
            send_item(g * $urandom_range(0, 65535), g * $urandom_range(1, 65535));
        end
    endtask

    // noise: any operands, with zero and unit moduli mixed in
    task automatic test_random_mixed(input int count);
        logic [IO_W-1:0] m;
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0:       m = 32'd0;
                1:       m = 32'd1;
                2, 3:    m = rand_narrow();
                default: m = $urandom;
            endcase
            send_item(($urandom_range(0, 1) == 0) ? rand_narrow() : $urandom, m);
        end
    endtask

    // sender holds off until the block has answered everything
    task automatic test_pause_drain(input int groups);
        repeat (groups)
        begin
            test_random_coprime($urandom_range(3, 8));
            drain();
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        value   = '0;
        modulus = '0;
        start_on        = 1'b0;
        burst_left      = 1;
        mismatches      = 0;
        items_sent      = 0;
        results_checked = 0;
        no_inverse_seen = 0;
        idle_cycles     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_moduli();
        test_degenerate_values();
        test_operand_extremes();
        test_random_coprime(110);
        test_random_shared_factor(35);
        test_random_mixed(90);
        test_pause_drain(5);
        drain();

        // catch any stray result after the last one
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("items sent %0d, results checked %0d, no-inverse results %0d",
                 items_sent, results_checked, no_inverse_seen);
        $display("covered unit and zero moduli, shared factors, extremes, random widths");
        if (mismatches == 0 && pending_inverses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mi_pkg.sv
rtl/mi_divider.sv
rtl/mi_datapath.sv
rtl/mi_ctrl.sv
rtl/modular_inverse.sv
bench/testbench.sv
